[rtl/grouped_ordered_key_table_assert.svh]
// assertion macros shared by the grouped ordered key table modules
`ifndef GROUPED_ORDERED_KEY_TABLE_ASSERT_SVH
`define GROUPED_ORDERED_KEY_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define GOKT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("grouped ordered key table assertion failed");
// antecedent this cycle requires consequent in the next cycle
`define GOKT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grouped ordered key table sequence assertion failed");
`else
`define GOKT_ASSERT(lbl, clk, rst_n, prop)
`define GOKT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/gokt_pkg.sv]
// types and constants of the grouped ordered key table
package gokt_pkg;

    // command opcodes
    typedef enum logic [2:0] {
        OP_ADD        = 3'd0,
        OP_REMOVE     = 3'd1,
        OP_GROUP_EXT  = 3'd2,
        OP_GLOBAL_EXT = 3'd3,
        OP_THRESH     = 3'd4
    } op_e;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_MISSING = 2'd2;

    // ordering key is level over id
    localparam int KEY_W = 24;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] item_id;
        logic [7:0]  item_level;
        logic [7:0]  item_group;
        logic        direction;
    } cmd_t;

    typedef struct packed {
        logic        found;
        logic [15:0] result_id;
        logic [1:0]  status;
    } rsp_t;

    // one slot word in the table RAM
    typedef struct packed {
        logic        valid;
        logic [15:0] id;
        logic [7:0]  level;
        logic [7:0]  group;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_e;

    // controller to datapath commands
    typedef struct packed {
        logic clear_wr;
        logic start;
        logic scan_rd;
        logic finish;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic cnt_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

[rtl/gokt_ram.sv]
// generic simple dual port RAM with registered read
module gokt_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/gokt_ctrl.sv]
// controller state machine of the grouped ordered key table
`include "grouped_ordered_key_table_assert.svh"

module gokt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  gokt_pkg::ctrl_sts_t  sts,
    output gokt_pkg::ctrl_cmd_t  ctrl
);

    gokt_pkg::state_e state_reg;
    gokt_pkg::state_e state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gokt_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        ctrl          = '0;
        cmd_stall     = 1'b1;
        unique case (state_reg)
            gokt_pkg::ST_CLEAR:
            begin
                ctrl.clear_wr = 1'b1;
                if (sts.cnt_last)
                begin
                    state_next = gokt_pkg::ST_IDLE;
                end
            end
            gokt_pkg::ST_IDLE:
            begin
                cmd_stall = 1'b0;
                if (cmd_valid)
                begin
                    ctrl.start = 1'b1;
                    state_next = gokt_pkg::ST_SCAN;
                end
            end
            gokt_pkg::ST_SCAN:
            begin
                ctrl.scan_rd = 1'b1;
                if (sts.cnt_last)
                begin
                    state_next = gokt_pkg::ST_DRAIN;
                end
            end
            gokt_pkg::ST_DRAIN:
            begin
                state_next = gokt_pkg::ST_FINISH;
            end
            gokt_pkg::ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = gokt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gokt_pkg::ST_IDLE;
            end
        endcase
    end

    // an accepted transaction always goes into the scan
    `GOKT_ASSERT_NEXT(a_start_scans, clk, rst_n, ctrl.start, state_reg == gokt_pkg::ST_SCAN)
    // input is held off outside the idle state
    `GOKT_ASSERT(a_stall_when_busy, clk, rst_n, (state_reg != gokt_pkg::ST_IDLE) |-> cmd_stall)
    // a taken result returns the controller to idle
    `GOKT_ASSERT_NEXT(a_finish_to_idle, clk, rst_n, ctrl.finish, state_reg == gokt_pkg::ST_IDLE)

endmodule

[rtl/gokt_datapath.sv]
// datapath of the grouped ordered key table: slot RAM, scan and result
`include "grouped_ordered_key_table_assert.svh"

module gokt_datapath #(
    parameter int ENTRIES = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gokt_pkg::ctrl_cmd_t  ctrl,
    output gokt_pkg::ctrl_sts_t  sts,
    input  gokt_pkg::cmd_t       cmd_data,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output gokt_pkg::rsp_t       rsp_data
);

    localparam int AW = $clog2(ENTRIES);

    logic [AW-1:0]                 cnt_reg;
    logic [AW-1:0]                 cnt_next;
    gokt_pkg::cmd_t                req_reg;
    logic                          pipe_valid_reg;
    logic [AW-1:0]                 pipe_idx_reg;
    logic                          have_reg;
    logic                          have_next;
    logic [gokt_pkg::KEY_W-1:0]    best_key_reg;
    logic [gokt_pkg::KEY_W-1:0]    best_key_next;
    logic                          match_hit_reg;
    logic                          match_hit_next;
    logic [AW-1:0]                 match_idx_reg;
    logic [AW-1:0]                 match_idx_next;
    logic                          free_hit_reg;
    logic                          free_hit_next;
    logic [AW-1:0]                 free_idx_reg;
    logic [AW-1:0]                 free_idx_next;
    gokt_pkg::rsp_t                rsp_reg;
    logic                          rsp_valid_reg;

    logic                          ram_wr_en;
    logic [AW-1:0]                 ram_wr_addr;
    gokt_pkg::slot_t               wr_slot;
    logic [gokt_pkg::SLOT_W-1:0]   ram_rd_data;
    gokt_pkg::slot_t               rd_slot;
    logic [gokt_pkg::KEY_W-1:0]    slot_key;
    logic                          want_max;
    logic                          sel_ok;
    logic                          better;
    gokt_pkg::rsp_t                res;

    // slot storage
    gokt_ram #(
        .WIDTH (gokt_pkg::SLOT_W),
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (wr_slot),
        .rd_en   (ctrl.scan_rd),
        .rd_addr (cnt_reg),
        .rd_data (ram_rd_data)
    );

    assign rd_slot  = gokt_pkg::slot_t'(ram_rd_data);
    assign slot_key = {rd_slot.level, rd_slot.id};

    // slot counter shared by clearing pass and scan
    assign sts.cnt_last = (cnt_reg == AW'(ENTRIES - 1));
    assign sts.out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctrl.start)
        begin
            cnt_next = '0;
        end
        else if (ctrl.clear_wr || ctrl.scan_rd)
        begin
            cnt_next = sts.cnt_last ? '0 : cnt_reg + AW'(1);
        end
    end

    // per-slot match test and ordering compare
    always_comb
    begin
        want_max = (req_reg.op == gokt_pkg::OP_THRESH) ? req_reg.direction
                                                       : !req_reg.direction;
        case (req_reg.op)
            gokt_pkg::OP_GROUP_EXT:
                sel_ok = (rd_slot.group == req_reg.item_group);
            gokt_pkg::OP_GLOBAL_EXT:
                sel_ok = 1'b1;
            gokt_pkg::OP_THRESH:
                sel_ok = req_reg.direction ? (rd_slot.level < req_reg.item_level)
                                           : (rd_slot.level >= req_reg.item_level);
            default:
                sel_ok = 1'b0;
        endcase
        sel_ok = sel_ok && rd_slot.valid;
        better = !have_reg || (want_max ? (slot_key > best_key_reg)
                                        : (slot_key < best_key_reg));
    end

    // scan accumulators
    always_comb
    begin
        have_next      = have_reg;
        best_key_next  = best_key_reg;
        match_hit_next = match_hit_reg;
        match_idx_next = match_idx_reg;
        free_hit_next  = free_hit_reg;
        free_idx_next  = free_idx_reg;
        if (ctrl.start)
        begin
            have_next      = 1'b0;
            match_hit_next = 1'b0;
            free_hit_next  = 1'b0;
        end
        else if (pipe_valid_reg)
        begin
            if (sel_ok && better)
            begin
                have_next     = 1'b1;
                best_key_next = slot_key;
            end
            if (rd_slot.valid && (rd_slot.id == req_reg.item_id) && !match_hit_reg)
            begin
                match_hit_next = 1'b1;
                match_idx_next = pipe_idx_reg;
            end
            if (!rd_slot.valid && !free_hit_reg)
            begin
                free_hit_next = 1'b1;
                free_idx_next = pipe_idx_reg;
            end
        end
    end

    // result and table update at the end of a transaction
    always_comb
    begin
        ram_wr_en   = ctrl.clear_wr;
        ram_wr_addr = cnt_reg;
        wr_slot     = '0;
        res         = '0;
        case (req_reg.op) inside
            gokt_pkg::OP_ADD:
            begin
                wr_slot.valid = 1'b1;
                wr_slot.id    = req_reg.item_id;
                wr_slot.level = req_reg.item_level;
                wr_slot.group = req_reg.item_group;
                if (match_hit_reg)
                begin
                    ram_wr_en   = ctrl.finish;
                    ram_wr_addr = match_idx_reg;
                end
                else if (free_hit_reg)
                begin
                    ram_wr_en   = ctrl.finish;
                    ram_wr_addr = free_idx_reg;
                end
                else
                begin
                    res.status = gokt_pkg::STATUS_FULL;
                end
            end
            gokt_pkg::OP_REMOVE:
            begin
                if (match_hit_reg)
                begin
                    ram_wr_en   = ctrl.finish;
                    ram_wr_addr = match_idx_reg;
                end
                else
                begin
                    res.status = gokt_pkg::STATUS_MISSING;
                end
            end
            gokt_pkg::OP_GROUP_EXT, gokt_pkg::OP_GLOBAL_EXT, gokt_pkg::OP_THRESH:
            begin
                res.found     = have_reg;
                res.result_id = have_reg ? best_key_reg[15:0] : 16'd0;
            end
            default:
            begin
                res = '0;
            end
        endcase
        // clearing pass always writes empty slots
        if (ctrl.clear_wr)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cnt_reg;
            wr_slot     = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            pipe_valid_reg <= 1'b0;
            have_reg       <= 1'b0;
            match_hit_reg  <= 1'b0;
            free_hit_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            pipe_valid_reg <= ctrl.scan_rd;
            have_reg       <= have_next;
            match_hit_reg  <= match_hit_next;
            free_hit_reg   <= free_hit_next;
            if (ctrl.finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pipe_idx_reg  <= cnt_reg;
        best_key_reg  <= best_key_next;
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
        if (ctrl.start)
        begin
            req_reg <= cmd_data;
        end
        if (ctrl.finish)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // table writes never overlap a scan read
    `GOKT_ASSERT(a_no_wr_during_scan, clk, rst_n, !(ram_wr_en && ctrl.scan_rd))
    // only an add puts a valid entry in the table
    `GOKT_ASSERT(a_set_only_on_add, clk, rst_n, (ram_wr_en && wr_slot.valid) |-> (req_reg.op == gokt_pkg::OP_ADD))
    // the scan pipeline is drained before a result is taken
    `GOKT_ASSERT(a_finish_drained, clk, rst_n, ctrl.finish |-> !pipe_valid_reg)

endmodule

[rtl/grouped_ordered_key_table.sv]
// top level of the grouped ordered key table
//
//  channel  | flow | handshake            | payload
//  ---------+------+----------------------+-----------------
//  cmd      | in   | cmd_valid/cmd_stall  | gokt_pkg::cmd_t
//  rsp      | out  | rsp_valid/rsp_stall  | gokt_pkg::rsp_t
//
// a result is presented after the scan, which reads one slot of the table RAM per cycle
// through its single read port, then a drain state and a finish state that registers it.
// the next transaction is accepted only once the controller is back in the idle state.
// after reset a clearing pass empties the table, cmd_stall high.
// one transaction is in flight at a time; cmd_stall is low only when idle.
// a result held by rsp_stall keeps the next transaction waiting in its finish state.
module grouped_ordered_key_table #(
    parameter int ENTRIES = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  gokt_pkg::cmd_t  cmd_data,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output gokt_pkg::rsp_t  rsp_data
);

    gokt_pkg::ctrl_cmd_t ctrl;
    gokt_pkg::ctrl_sts_t sts;

    // sequencing
    gokt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .sts       (sts),
        .ctrl      (ctrl)
    );

    // table and scan logic
    gokt_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .sts       (sts),
        .cmd_data  (cmd_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

[tb/grouped_ordered_key_table_check.sv]
// checker for the grouped ordered key table: shadow table, response prediction and compare
module grouped_ordered_key_table_check #(
    parameter int ENTRIES = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  logic           cmd_stall,
    input  gokt_pkg::cmd_t cmd_data,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  gokt_pkg::rsp_t rsp_data,
    input  logic           run_over,
    output int             error_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow copy of the table
    bit        shadow_used  [ENTRIES];
    bit [15:0] shadow_id    [ENTRIES];
    bit [7:0]  shadow_level [ENTRIES];
    bit [7:0]  shadow_group [ENTRIES];

    // responses still owed by the block, oldest first
    gokt_pkg::rsp_t pending_rsp_q [$];
    int   failures = 0;
    bit   leftover_checked = 1'b0;

    assign error_count = failures;

    task automatic note_mismatch(input string what, input int want, input int got);
        failures++;
        if (failures <= 10)
            $display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
    endtask

    // returns the slot holding id, or -1
    function automatic int slot_of_id(input bit [15:0] id);
        int slot;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && shadow_used[i] && shadow_id[i] == id)
                slot = i;
        return slot;
    endfunction

    // apply one command to the shadow table and work out its response
    task automatic apply_command(input gokt_pkg::cmd_t c, output gokt_pkg::rsp_t r);
        int        slot;
        bit        want_max;
        bit        have;
        bit        match;
        bit [23:0] best;
        bit [23:0] key;
        r = '0;
        case (c.op) inside
            gokt_pkg::OP_ADD:
            begin
                slot = slot_of_id(c.item_id);
                for (int i = 0; i < ENTRIES; i++)
                    if (slot < 0 && !shadow_used[i])
                        slot = i;
                if (slot < 0)
                    r.status = gokt_pkg::STATUS_FULL;
                else
                begin
                    shadow_used[slot]  = 1'b1;
                    shadow_id[slot]    = c.item_id;
                    shadow_level[slot] = c.item_level;
                    shadow_group[slot] = c.item_group;
                end
            end
            gokt_pkg::OP_REMOVE:
            begin
                slot = slot_of_id(c.item_id);
                if (slot < 0)
                    r.status = gokt_pkg::STATUS_MISSING;
                else
                    shadow_used[slot] = 1'b0;
            end
            gokt_pkg::OP_GROUP_EXT, gokt_pkg::OP_GLOBAL_EXT, gokt_pkg::OP_THRESH:
            begin
                // threshold: dir 0 is lowest at or above, dir 1 highest below
                want_max = (c.op == gokt_pkg::OP_THRESH) ? c.direction : !c.direction;
                have = 1'b0;
                best = '0;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (shadow_used[i])
                    begin
                        case (c.op)
                            gokt_pkg::OP_GROUP_EXT:
                                match = (shadow_group[i] == c.item_group);
                            gokt_pkg::OP_GLOBAL_EXT:
                                match = 1'b1;
                            default:
                                match = c.direction ?
                                        (shadow_level[i] <  c.item_level) :
                                        (shadow_level[i] >= c.item_level);
                        endcase
                        key = {shadow_level[i], shadow_id[i]};
                        if (match && (!have || (want_max ? key > best : key < best)))
                        begin
                            best = key;
                            have = 1'b1;
                        end
                    end
                end
                if (have)
                begin
                    r.found     = 1'b1;
                    r.result_id = best[15:0];
                end
            end
            default: ;
        endcase
    endtask

    // watch both channels
    always @(posedge clk or negedge rst_n)
    begin
        gokt_pkg::rsp_t want;
        gokt_pkg::rsp_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                shadow_used[i] = 1'b0;
            pending_rsp_q.delete();
        end
        else
        begin
            // response transaction against the oldest prediction
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_rsp_q.size() == 0)
                    note_mismatch("unexpected response, id", 0, rsp_data.result_id);
                else
                begin
                    want = pending_rsp_q.pop_front();
                    got  = rsp_data;
                    if (got.found !== want.found)
                        note_mismatch("found", want.found, got.found);
                    if (got.result_id !== want.result_id)
                        note_mismatch("result_id", want.result_id, got.result_id);
                    if (got.status !== want.status)
                        note_mismatch("status", want.status, got.status);
                end
            end
            // command transaction updates the shadow table
            if (cmd_valid && !cmd_stall)
            begin
                apply_command(cmd_data, want);
                pending_rsp_q.push_back(want);
            end
            // anything still owed at the end is lost
            if (run_over && !leftover_checked)
            begin
                leftover_checked = 1'b1;
                if (pending_rsp_q.size() != 0)
                    note_mismatch("responses outstanding", 0, pending_rsp_q.size());
            end
        end
    end

endmodule

[tb/grouped_ordered_key_table_test.sv]
// testbench top for the grouped ordered key table: stimulus, flow control and verdict
module grouped_ordered_key_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES        = 256;
    localparam int IDLE_PCT       = 13;
    localparam int HOLD_CYCLES    = 700;
    localparam int HOLD_AT_RSP    = 100;
    localparam int QUIET_LO       = 300;
    localparam int QUIET_HI       = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MIX_ITEMS      = 170;
    localparam int FILL_ITEMS     = 320;
    localparam int DRAIN_ITEMS    = 60;

    // random traffic flavors
    localparam int PH_MIX   = 0;
    localparam int PH_FILL  = 1;
    localparam int PH_DRAIN = 2;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           cmd_valid = 1'b0;
    logic           cmd_stall;
    gokt_pkg::cmd_t cmd_data  = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    gokt_pkg::rsp_t rsp_data;
    logic           run_over  = 1'b0;
    int             error_count;

    int        sent_count = 0;
    int        rsp_count  = 0;
    bit [15:0] id_pool [24];
    bit [15:0] added_ids [$];

    grouped_ordered_key_table #(
        .ENTRIES (ENTRIES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    grouped_ordered_key_table_check #(
        .ENTRIES (ENTRIES)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd_data    (cmd_data),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_data    (rsp_data),
        .run_over    (run_over),
        .error_count (error_count)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic gokt_pkg::cmd_t make_cmd(input logic [2:0] op, input bit [15:0] id,
                                                input bit [7:0] lvl, input bit [7:0] grp,
                                                input bit dir);
        gokt_pkg::cmd_t c;
        c.op         = op;
        c.item_id    = id;
        c.item_level = lvl;
        c.item_group = grp;
        c.direction  = dir;
        return c;
    endfunction

    function automatic bit [7:0] random_level();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return 8'h00;
        if (r < 15)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    // few groups so group queries usually hit
    function automatic bit [7:0] random_group();
        if ($urandom_range(99) < 80)
            return 8'($urandom_range(3));
        return 8'($urandom_range(255));
    endfunction

    function automatic bit [15:0] pool_id();
        return id_pool[$urandom_range(23)];
    endfunction

    // one random command shaped by the traffic flavor
    function automatic gokt_pkg::cmd_t random_command(input int flavor);
        gokt_pkg::cmd_t c;
        int   r;
        c = make_cmd(3'($urandom_range(7)), 16'($urandom_range(65535)),
                     random_level(), random_group(), 1'($urandom_range(1)));
        r = $urandom_range(99);
        case (flavor)
            PH_MIX:
            begin
                if ($urandom_range(99) < 75)
                    c.item_id = pool_id();
                if (r < 35)
                    c.op = gokt_pkg::OP_ADD;
                else if (r < 55)
                    c.op = gokt_pkg::OP_REMOVE;
                else if (r < 68)
                    c.op = gokt_pkg::OP_GROUP_EXT;
                else if (r < 78)
                    c.op = gokt_pkg::OP_GLOBAL_EXT;
                else if (r < 95)
                    c.op = gokt_pkg::OP_THRESH;
                else
                    c.op = 3'($urandom_range(5, 7));
            end
            PH_FILL:
            begin
                // mostly fresh ids so the table runs full
                if (r < 88)
                begin
                    c.op = gokt_pkg::OP_ADD;
                    if ($urandom_range(99) >= 92)
                        c.item_id = pool_id();
                end
                else if (r < 93)
                    c.op = gokt_pkg::OP_GROUP_EXT;
                else if (r < 96)
                    c.op = gokt_pkg::OP_GLOBAL_EXT;
                else
                    c.op = gokt_pkg::OP_THRESH;
            end
            default:
            begin
                if (r < 50)
                begin
                    c.op = gokt_pkg::OP_REMOVE;
                    if (added_ids.size() != 0)
                        c.item_id = added_ids[$urandom_range(added_ids.size() - 1)];
                end
                else if (r < 65)
                    c.op = gokt_pkg::OP_ADD;
                else if (r < 80)
                    c.op = gokt_pkg::OP_GROUP_EXT;
                else if (r < 90)
                    c.op = gokt_pkg::OP_GLOBAL_EXT;
                else
                    c.op = gokt_pkg::OP_THRESH;
            end
        endcase
        if (c.op == gokt_pkg::OP_ADD)
            added_ids.push_back(c.item_id);
        return c;
    endfunction

    // offer one command transaction and wait for its acceptance
    task automatic offer_command(input gokt_pkg::cmd_t c);
        bool_quiet:
        begin
            if (!(sent_count >= QUIET_LO && sent_count < QUIET_HI) &&
                $urandom_range(99) < IDLE_PCT)
            begin
                cmd_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        cmd_data  <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sent_count++;
    endtask

    // stimulus and verdict
    initial
    begin
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (int i = 2; i < 24; i++)
            id_pool[i] = 16'($urandom_range(65535));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, extremes, ties on level, replace, remove, unused ops
        offer_command(make_cmd(gokt_pkg::OP_GLOBAL_EXT, 16'h0000, 8'h00, 8'h00, 1'b0));
        offer_command(make_cmd(gokt_pkg::OP_GLOBAL_EXT, 16'h0000, 8'h00, 8'h00, 1'b1));
        offer_command(make_cmd(gokt_pkg::OP_THRESH,     16'h0000, 8'h00, 8'h00, 1'b0));
        offer_command(make_cmd(gokt_pkg::OP_REMOVE,     16'hFFFF, 8'h00, 8'h00, 1'b0));
        offer_command(make_cmd(gokt_pkg::OP_ADD,        16'h0000, 8'h00, 8'h00, 1'b0));
        offer_command(make_cmd(gokt_pkg::OP_ADD,        16'hFFFF, 8'hFF, 8'hFF, 1'b1));
        offer_command(make_cmd(gokt_pkg::OP_ADD,        16'h1234, 8'h80, 8'h00, 1'b0));
        offer_command(make_cmd(gokt_pkg::OP_ADD,        16'h00FF, 8'h80, 8'h00, 1'b0));
        offer_command(make_cmd(gokt_pkg::OP_GROUP_EXT,  16'h0000, 8'h00, 8'h00, 1'b0));
        offer_command(make_cmd(gokt_pkg::OP_GROUP_EXT,  16'h0000, 8'h00, 8'h00, 1'b1));
        offer_command(make_cmd(gokt_pkg::OP_GROUP_EXT,  16'h0000, 8'h00, 8'h07, 1'b0));
        offer_command(make_cmd(gokt_pkg::OP_GLOBAL_EXT, 16'h0000, 8'h00, 8'h00, 1'b0));
        offer_command(make_cmd(gokt_pkg::OP_GLOBAL_EXT, 16'h0000, 8'h00, 8'h00, 1'b1));
        offer_command(make_cmd(gokt_pkg::OP_THRESH,     16'h0000, 8'h80, 8'h00, 1'b0));
        offer_command(make_cmd(gokt_pkg::OP_THRESH,     16'h0000, 8'h80, 8'h00, 1'b1));
        offer_command(make_cmd(gokt_pkg::OP_THRESH,     16'h0000, 8'h00, 8'h00, 1'b1));
        offer_command(make_cmd(gokt_pkg::OP_THRESH,     16'h0000, 8'hFF, 8'h00, 1'b0));
        offer_command(make_cmd(gokt_pkg::OP_ADD,        16'h1234, 8'h05, 8'h09, 1'b0));
        offer_command(make_cmd(gokt_pkg::OP_GROUP_EXT,  16'h0000, 8'h00, 8'h09, 1'b0));
        offer_command(make_cmd(gokt_pkg::OP_REMOVE,     16'h1234, 8'h00, 8'h00, 1'b0));
        offer_command(make_cmd(gokt_pkg::OP_REMOVE,     16'h1234, 8'h00, 8'h00, 1'b0));
        offer_command(make_cmd(3'd5,                    16'hA5A5, 8'h5A, 8'hC3, 1'b1));
        offer_command(make_cmd(3'd6,                    16'hFFFF, 8'hFF, 8'hFF, 1'b1));
        offer_command(make_cmd(3'd7,                    16'h0001, 8'h01, 8'h01, 1'b0));
        offer_command(make_cmd(gokt_pkg::OP_THRESH,     16'h0000, 8'hFF, 8'h00, 1'b1));

        // random traffic on a small id set
        for (int n = 0; n < MIX_ITEMS; n++)
            offer_command(random_command(PH_MIX));

        // let everything drain before filling the table
        cmd_valid <= 1'b0;
        wait (rsp_count == sent_count);

        // fill past capacity, then free slots again
        for (int n = 0; n < FILL_ITEMS; n++)
            offer_command(random_command(PH_FILL));
        for (int n = 0; n < DRAIN_ITEMS; n++)
            offer_command(random_command(PH_DRAIN));

        cmd_valid <= 1'b0;
        wait (rsp_count == sent_count);
        repeat (ENTRIES + 8) @(posedge clk);
        run_over <= 1'b1;
        repeat (3) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // response side: random stalls, one long hold, one quiet stretch
    initial
    begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
                rsp_count++;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (!held && rsp_count == HOLD_AT_RSP)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
                rsp_stall <= 1'b1;
            end
            else if (rsp_count >= QUIET_LO && rsp_count < QUIET_HI)
                rsp_stall <= 1'b0;
            else
                rsp_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    // watchdog on cycles without any transaction
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout after %0d cycles without a transaction", idle_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule

[grouped_ordered_key_table.f]
+incdir+rtl
rtl/gokt_pkg.sv
rtl/gokt_ram.sv
rtl/gokt_ctrl.sv
rtl/gokt_datapath.sv
rtl/grouped_ordered_key_table.sv
tb/grouped_ordered_key_table_check.sv
tb/grouped_ordered_key_table_test.sv
